>>> sv/sca_pkg.sv
// Shared types and constants for the sighting-count admission filter.
package sca_pkg;

    // Sighting counts and thresholds
    localparam int COUNT_BITS = 8;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX        = 8'hFF;
    localparam count_t COUNT_FIRST      = 8'd1;
    localparam count_t USER_THRESHOLD   = 8'd1;
    localparam count_t AUTO_THRESH_RST  = 8'd2;

    // Default table geometry
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF      = 64;

endpackage

>>> sv/sighting_count_admission_filter.sv
// Sighting-count admission filter: associative per-key counter table and record decision.

// The block takes one transfer per clock when the output side keeps up: an input
// register holds the item, combinational logic compares its key against every
// table entry in parallel, updates the matching (or newly inserted) entry's
// saturating count, and loads the result register; throughput is one item per
// cycle while the output does not stall. The rate is set by the combinational compare over
// TABLE_ENTRIES key comparators; each item sees the table as left by the item before.
// Entries fill in order from slot 0. A miss on a full table wipes all entries,
// inserts the key at slot 0 and flags table_cleared on that result. The table needs
// no clearing pass after reset. The user writes auto_threshold through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module sighting_count_admission_filter #(
    parameter int TABLE_ENTRIES = sca_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = sca_pkg::KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  sca_pkg::count_t     cfg_wdata,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [KEY_BITS-1:0] lookup_key,
    input  logic                origin_user,
    input  logic                trail_empty,
    input  logic                trail_overflowed,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output sca_pkg::count_t     sighting_count,
    output logic                record_now,
    output logic                table_cleared
);
    import sca_pkg::*;

    localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OCC_BITS = $clog2(TABLE_ENTRIES + 1);
    localparam logic [OCC_BITS-1:0] OCC_FULL = OCC_BITS'(TABLE_ENTRIES);

    // Configuration register
    count_t auto_threshold_reg;

    // Input register
    logic                in_valid_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                user_reg;
    logic                empty_reg;
    logic                over_reg;

    // Table
    logic [KEY_BITS-1:0]      entry_key_reg   [TABLE_ENTRIES];
    count_t                   entry_count_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] entry_valid_reg;
    logic [OCC_BITS-1:0]      occupancy_reg;

    // Result register
    logic   out_valid_reg;
    count_t count_out_reg;
    logic   record_out_reg;
    logic   cleared_out_reg;

    // Datapath
    logic                     advance;
    logic                     process;
    logic [TABLE_ENTRIES-1:0] hit_vec;
    logic                     hit;
    logic                     full;
    logic                     do_clear;
    logic [IDX_BITS-1:0]      ins_idx;
    logic [TABLE_ENTRIES-1:0] wr_vec;
    count_t                   hit_count;
    count_t                   new_count;
    count_t                   threshold;
    logic                     record_next;

    // Flow control: result register frees or drains, input register refills
    assign advance  = !out_valid_reg || !out_stall;
    assign process  = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // Key match against every valid entry; keys are unique so at most one hits
    always_comb
    begin
        hit_count = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit_vec[i] = entry_valid_reg[i] && (entry_key_reg[i] == key_reg);
            hit_count  = hit_count | (entry_count_reg[i] & {COUNT_BITS{hit_vec[i]}});
        end
    end

    assign hit      = |hit_vec;
    assign full     = (occupancy_reg == OCC_FULL);
    assign do_clear = !hit && full;
    // Entries fill in order, so the first free slot is the occupancy
    assign ins_idx  = do_clear ? '0 : occupancy_reg[IDX_BITS-1:0];

    // Entry to write on this item
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            wr_vec[i] = hit ? hit_vec[i] : (ins_idx == IDX_BITS'(i));
        end
    end

    // Saturating count and record decision
    always_comb
    begin
        if (!hit)
        begin
            new_count = COUNT_FIRST;
        end
        else if (hit_count == COUNT_MAX)
        begin
            new_count = COUNT_MAX;
        end
        else
        begin
            new_count = hit_count + COUNT_FIRST;
        end
        threshold   = user_reg ? USER_THRESHOLD : auto_threshold_reg;
        record_next = !empty_reg && !over_reg && (new_count >= threshold);
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_threshold_reg <= AUTO_THRESH_RST;
        end
        else if (cfg_we)
        begin
            auto_threshold_reg <= cfg_wdata;
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            key_reg   <= lookup_key;
            user_reg  <= origin_user;
            empty_reg <= trail_empty;
            over_reg  <= trail_overflowed;
        end
    end

    // Valid bits and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            occupancy_reg   <= '0;
        end
        else if (process && !hit)
        begin
            if (do_clear)
            begin
                entry_valid_reg <= TABLE_ENTRIES'(1);
                occupancy_reg   <= OCC_BITS'(1);
            end
            else
            begin
                entry_valid_reg <= entry_valid_reg | wr_vec;
                occupancy_reg   <= occupancy_reg + OCC_BITS'(1);
            end
        end
    end

    // Table keys and counts
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (process && wr_vec[i])
            begin
                entry_key_reg[i]   <= key_reg;
                entry_count_reg[i] <= new_count;
            end
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            count_out_reg   <= new_count;
            record_out_reg  <= record_next;
            cleared_out_reg <= do_clear;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sighting_count = count_out_reg;
    assign record_now     = record_out_reg;
    assign table_cleared  = cleared_out_reg;

    // Checks
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("key matches more than one table entry");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg <= OCC_FULL)
        else $error("occupancy beyond table size");

    a_occ_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(entry_valid_reg) == int'(occupancy_reg))
        else $error("occupancy disagrees with valid bits");

    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        process && do_clear |=> out_valid_reg && cleared_out_reg
                                && count_out_reg == COUNT_FIRST
                                && occupancy_reg == OCC_BITS'(1))
        else $error("table wipe did not restart with one entry");

endmodule
